// ----- rtl/pba_pkg.sv -----
// shared types and constants of the page bitmap allocator
package pba_pkg;

    localparam int PAGE_COUNT = 1024;
    localparam int PAGE_W     = 10;
    localparam int REG_W      = 11;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int ROW_COUNT  = PAGE_COUNT / WORD_BITS;
    localparam int ROW_W      = $clog2(ROW_COUNT);

    // command opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_FIRST_PAGE = 2'd0;
    localparam logic [1:0] CFG_END_PAGE   = 2'd1;

    // one bitmap row: allocated and usable bits of WORD_BITS pages
    typedef struct packed {
        logic [WORD_BITS-1:0] alloc;
        logic [WORD_BITS-1:0] usable;
    } t_row_word;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        t_row_word        wr_word;
    } t_ram_req;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_pos;
    } t_scan_res;

endpackage

// ----- rtl/pba_bitmap_ram.sv -----
// bitmap row memory with per-row valid bits, unwritten rows read as zero
module pba_bitmap_ram
    import pba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ram_req  i_req,
    output t_row_word o_rd_word
);

    t_row_word              r_mem [ROW_COUNT];
    t_row_word              r_rd_word;
    logic                   r_rd_valid;
    logic [ROW_COUNT-1:0]   r_row_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_row] <= i_req.wr_word;
        end
        if (i_req.rd_en) begin
            r_rd_word  <= r_mem[i_req.rd_row];
            r_rd_valid <= r_row_valid[i_req.rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_req.wr_en) begin
            r_row_valid[i_req.wr_row] <= 1'b1;
        end
    end

    assign o_rd_word = r_rd_valid ? r_rd_word : '0;

endmodule

// ----- rtl/pba_word_scan.sv -----
// masked find-first-set over one bitmap row
module pba_word_scan
    import pba_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_cand,
    input  logic [BIT_W-1:0]     i_lo_off,
    input  logic                 i_hi_en,
    input  logic [BIT_W-1:0]     i_hi_off,
    output t_scan_res            o_res
);

    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] masked;

    assign lo_mask = {WORD_BITS{1'b1}} << i_lo_off;
    assign hi_mask = i_hi_en ? ~({WORD_BITS{1'b1}} << i_hi_off) : {WORD_BITS{1'b1}};
    assign masked  = i_cand & lo_mask & hi_mask;

    // lowest set bit wins
    always_comb begin
        o_res.found   = |masked;
        o_res.bit_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                o_res.bit_pos = BIT_W'(i);
            end
        end
    end

endmodule

// ----- rtl/page_bitmap_allocator_core.sv -----
// page bitmap allocator top level: command sequencer, hint and config registers
//
// command channel: a transaction is taken when start is high and busy is low,
// carrying i_opcode (allocate, free, load usable bit), i_page_index and
// i_usable_value. every command gives exactly one result, shown on
// o_result_page and o_done_res for one cycle while o_res_strobe is high;
// the receiver cannot stall, so the result is gone after that cycle.
// config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is first_page, index 1 is end_page, others are dropped. ready is
// always high; write only while no command is in flight.
// an unknown opcode or an empty scan window is answered straight from idle;
// free and load read the row, then write it back, and an allocate visits
// the bitmap rows of 32 pages in the scan window in turn; the scan is paced
// by one row read per cycle from the bitmap memory. busy stays high until
// the strobe cycle, where the next command may already be taken.
// reset clears the row valid bits at once (no sweep), so all pages read as
// unusable and free; hint and first_page reset to 1, end_page to 1024.
module page_bitmap_allocator_core
    import pba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_opcode,
    input  logic [PAGE_W-1:0] i_page_index,
    input  logic              i_usable_value,
    output logic              o_res_strobe,
    output logic [PAGE_W-1:0] o_result_page,
    output logic              o_done_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [REG_W-1:0]  i_cfg_data
);

    localparam logic [REG_W-1:0] PAGE_LIMIT = REG_W'(PAGE_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_MODIFY
    } t_state;

    t_state              r_state, n_state;
    logic [REG_W-1:0]    r_first, n_first;
    logic [REG_W-1:0]    r_end, n_end;
    logic [REG_W-1:0]    r_hint, n_hint;
    logic [1:0]          r_op, n_op;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic                r_uval, n_uval;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [REG_W-1:0]    r_lo, n_lo;
    logic [REG_W-1:0]    r_hi, n_hi;
    logic                r_strobe, n_strobe;
    logic [PAGE_W-1:0]   r_result, n_result;
    logic                r_done, n_done;

    t_ram_req            ram_req;
    t_row_word           rd_word;
    t_row_word           mod_word;
    t_scan_res           scan_res;

    logic [REG_W-1:0]    win_lo;
    logic [REG_W-1:0]    win_hi;
    logic [BIT_W-1:0]    scan_lo_off;
    logic                scan_hi_en;
    logic [REG_W-1:0]    next_base;
    logic [PAGE_W-1:0]   found_page;
    logic [BIT_W-1:0]    page_bit;

    pba_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_word (rd_word)
    );

    // scan window edges only matter on rows that contain them
    assign scan_lo_off = (r_row == r_lo[PAGE_W-1:BIT_W]) ? r_lo[BIT_W-1:0] : '0;
    assign scan_hi_en  = ({1'b0, r_row} == r_hi[REG_W-1:BIT_W]);

    pba_word_scan u_scan (
        .i_cand   (rd_word.usable & ~rd_word.alloc),
        .i_lo_off (scan_lo_off),
        .i_hi_en  (scan_hi_en),
        .i_hi_off (r_hi[BIT_W-1:0]),
        .o_res    (scan_res)
    );

    assign win_lo     = (r_hint > r_first) ? r_hint : r_first;
    assign win_hi     = (r_end < PAGE_LIMIT) ? r_end : PAGE_LIMIT;
    // first page of the row after the current one
    assign next_base  = {REG_W'({1'b0, r_row} + 1'b1)} << BIT_W;
    assign found_page = {r_row, scan_res.bit_pos};
    assign page_bit   = r_page[BIT_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_first  = r_first;
        n_end    = r_end;
        n_hint   = r_hint;
        n_op     = r_op;
        n_page   = r_page;
        n_uval   = r_uval;
        n_row    = r_row;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_strobe = 1'b0;
        n_result = '0;
        n_done   = 1'b0;
        mod_word = rd_word;
        ram_req  = '0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIRST_PAGE: n_first = i_cfg_data;
                CFG_END_PAGE:   n_end   = i_cfg_data;
                default:        ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_opcode;
                    n_page = i_page_index;
                    n_uval = i_usable_value;
                    unique case (i_opcode) inside
                        OP_ALLOC: begin
                            if (win_lo >= win_hi) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_lo    = win_lo;
                                n_hi    = win_hi;
                                n_row   = win_lo[PAGE_W-1:BIT_W];
                                n_state = S_READ;
                            end
                        end
                        OP_FREE, OP_LOAD: begin
                            n_row   = i_page_index[PAGE_W-1:BIT_W];
                            n_state = S_READ;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                ram_req.rd_en  = 1'b1;
                ram_req.rd_row = r_row;
                n_state = (r_op == OP_ALLOC) ? S_SCAN : S_MODIFY;
            end
            S_SCAN: begin
                // fetch the following row while this one is checked
                ram_req.rd_en  = 1'b1;
                ram_req.rd_row = r_row + 1'b1;
                if (scan_res.found) begin
                    mod_word.alloc[scan_res.bit_pos] = 1'b1;
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_row  = r_row;
                    ram_req.wr_word = mod_word;
                    n_hint   = REG_W'({1'b0, found_page} + 1'b1);
                    n_strobe = 1'b1;
                    n_result = found_page;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (next_base < r_hi) begin
                    n_row = r_row + 1'b1;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_MODIFY: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                ram_req.wr_row = r_row;
                unique case (r_op)
                    OP_FREE: begin
                        if (rd_word.alloc[page_bit]) begin
                            mod_word.alloc[page_bit] = 1'b0;
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_word = mod_word;
                            n_done = 1'b1;
                            if ({1'b0, r_page} < r_hint) begin
                                n_hint = {1'b0, r_page};
                            end
                        end
                    end
                    OP_LOAD: begin
                        mod_word.usable[page_bit] = r_uval;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_word = mod_word;
                        n_done = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_first  <= REG_W'(1);
            r_end    <= PAGE_LIMIT;
            r_hint   <= REG_W'(1);
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_first  <= n_first;
            r_end    <= n_end;
            r_hint   <= n_hint;
            r_strobe <= n_strobe;
        end
        r_op     <= n_op;
        r_page   <= n_page;
        r_uval   <= n_uval;
        r_row    <= n_row;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_result <= n_result;
        r_done   <= n_done;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_res_strobe  = r_strobe;
    assign o_result_page = r_result;
    assign o_done_res    = r_done;

`ifndef SYNTHESIS
    // a result only comes out once the sequencer is back in idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE))
        else $error("result strobe while a command is in flight");

    // every accepted command either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || r_strobe))
        else $error("accepted command dropped");

    // page field is zero unless a page was allocated
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_done) |-> (r_result == '0))
        else $error("nonzero page on a failed command");

    // hint never runs past the end of the table
    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= PAGE_LIMIT)
        else $error("search hint out of range");
`endif

endmodule
